### hdl/keyed_price_table_top_assert.svh
// assertion macros for the keyed price table
`ifndef KEYED_PRICE_TABLE_TOP_ASSERT_SVH
`define KEYED_PRICE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/kpt_pkg.sv
`default_nettype none
package kpt_pkg;
    localparam int TABLE_DEPTH = 128;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         found_index;
        logic signed [31:0] found_value;
        logic [7:0]         entry_count;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOC_RD,   // issue read of scan entry
        S_LOC_WT,
        S_LOC_CMP,
        S_ADD_WR,
        S_RM_RD,    // read entry pos+1
        S_RM_WT,
        S_RM_WR,
        S_SO_RDI,   // outer: read entry i (min candidate)
        S_SO_WTI,
        S_SO_LDI,
        S_SO_RDJ,
        S_SO_WTJ,
        S_SO_CMP,
        S_SO_WRM,   // write entry i into slot m
        S_SO_WRI,   // write min into slot i
        S_BS_RD,
        S_BS_WT,
        S_BS_CMP,
        S_DONE
    } t_state;

    // signed less-than via order-preserving flip
    function automatic logic key_lt(input logic [31:0] a, input logic [31:0] b);
        key_lt = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
    endfunction
endpackage
`default_nettype wire

### hdl/keyed_price_table_top.sv
`default_nettype none
// keyed price table: up to 128 signed key/value pairs in one ram
// a command word is taken on a cycle with start high and busy low;
// busy stays high until its result word is shown on o_result for one
// cycle with o_done high. the receiver cannot stall; next start clears it.
// ops: add (rejects duplicate keys, flags full), remove (shifts later
// entries down), sort (selection sort by signed key), search (sort, then
// binary search returning sorted index and value).
// run time is set by the single ram port pair: every key compare in the
// scan, the sort and the binary search needs a read, and each remove shift
// a read and a write. one command is worked at a time; a new one is taken
// only while busy is low.
// reset empties the table (count to zero); ram contents are left as they are.
module keyed_price_table_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire kpt_pkg::t_in_word i_cmd,
    output logic                   o_done,
    output kpt_pkg::t_out_word     o_result
);
    import kpt_pkg::*;

    t_state r_state, n_state;
    t_in_word r_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;      // scan / outer index / lo
    logic [CW-1:0] r_j, n_j;      // inner index / hi
    logic [CW-1:0] r_m, n_m;      // min index / mid
    logic [63:0] r_min, n_min;    // min key/value, seeded with entry i
    logic [63:0] r_ent_i, n_ent_i;
    t_out_word r_res, n_res;
    logic r_done, n_done;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    kpt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [31:0] rd_key;
    logic [CW:0] mid_sum;
    assign rd_key  = rdata[63:32];
    assign mid_sum = {1'b0, r_i} + {1'b0, r_j} - 1'b1;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_cmd   <= (start && !busy) ? i_cmd : r_cmd;
        r_i     <= n_i;
        r_j     <= n_j;
        r_m     <= n_m;
        r_min   <= n_min;
        r_ent_i <= n_ent_i;
        r_res   <= n_res;
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i = r_i; n_j = r_j; n_m = r_m;
        n_min = r_min; n_ent_i = r_ent_i;
        n_res = r_res;
        n_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    n_i = '0;
                    unique case (i_cmd.op) inside
                        OP_ADD, OP_REMOVE: n_state = S_LOC_RD;
                        default:           n_state = S_SO_RDI;
                    endcase
                end
            end
            S_LOC_RD: begin
                if (r_i >= r_count) begin
                    // key absent
                    if (r_cmd.op == OP_REMOVE) begin
                        n_res.status = ST_MISS;
                        n_state = S_DONE;
                    end else if (r_count >= CW'(TABLE_DEPTH)) begin
                        n_res.status = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADD_WR;
                    end
                end else begin
                    n_state = S_LOC_WT;
                end
            end
            S_LOC_WT: n_state = S_LOC_CMP;
            S_LOC_CMP: begin
                if (rd_key == r_cmd.key) begin
                    if (r_cmd.op == OP_ADD) begin
                        n_res.status = ST_DUP;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RM_RD;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_LOC_RD;
                end
            end
            S_ADD_WR: begin
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_RM_RD: begin
                if (r_i + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RM_WT;
                end
            end
            S_RM_WT: n_state = S_RM_WR;
            S_RM_WR: begin
                n_i = r_i + 1'b1;
                n_state = S_RM_RD;
            end
            S_SO_RDI: begin
                if (r_i + 1'b1 >= r_count) begin
                    if (r_cmd.op == OP_SEARCH) begin
                        n_i = '0;
                        n_j = r_count;
                        n_state = S_BS_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SO_WTI;
                end
            end
            S_SO_WTI: n_state = S_SO_LDI;
            S_SO_LDI: begin
                n_min = rdata;
                n_ent_i = rdata;
                n_m = r_i;
                n_j = r_i + 1'b1;
                n_state = S_SO_RDJ;
            end
            S_SO_RDJ: begin
                if (r_j >= r_count) begin
                    n_state = S_SO_WRM;
                end else begin
                    n_state = S_SO_WTJ;
                end
            end
            S_SO_WTJ: n_state = S_SO_CMP;
            S_SO_CMP: begin
                if (key_lt(rd_key, r_min[63:32])) begin
                    n_min = rdata;
                    n_m = r_j;
                end
                n_j = r_j + 1'b1;
                n_state = S_SO_RDJ;
            end
            S_SO_WRM: n_state = S_SO_WRI;
            S_SO_WRI: begin
                n_i = r_i + 1'b1;
                n_state = S_SO_RDI;
            end
            S_BS_RD: begin
                if (r_i < r_j) begin
                    n_m = mid_sum[CW:1];
                    n_state = S_BS_WT;
                end else begin
                    n_res.status = ST_MISS;
                    n_state = S_DONE;
                end
            end
            S_BS_WT: n_state = S_BS_CMP;
            S_BS_CMP: begin
                if (rd_key == r_cmd.key) begin
                    n_res.found_index = r_m[6:0];
                    n_res.found_value = rdata[31:0];
                    n_state = S_DONE;
                end else if (key_lt(rd_key, r_cmd.key)) begin
                    n_i = r_m + 1'b1;
                    n_state = S_BS_RD;
                end else begin
                    n_j = r_m;
                    n_state = S_BS_RD;
                end
            end
            S_DONE: begin
                n_res.entry_count = 8'(r_count);
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ram port control
    always_comb begin
        we = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = r_ent_i;
        raddr = r_i[AW-1:0];
        unique case (r_state) inside
            S_ADD_WR: begin
                we = 1'b1;
                waddr = r_count[AW-1:0];
                wdata = {r_cmd.key, r_cmd.value};
            end
            S_RM_RD:  raddr = AW'(r_i + 1'b1);
            S_RM_WT:  raddr = AW'(r_i + 1'b1);
            S_RM_WR: begin
                we = 1'b1;
                wdata = rdata;
            end
            S_SO_RDJ, S_SO_WTJ: raddr = r_j[AW-1:0];
            S_SO_WRM: begin
                we = 1'b1;
                waddr = r_m[AW-1:0];
                wdata = r_ent_i;
            end
            S_SO_WRI: begin
                we = 1'b1;
                wdata = r_min;
            end
            S_BS_WT, S_BS_CMP: raddr = r_m[AW-1:0];
            default: ;
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    `include "keyed_price_table_top_assert.svh"

    `KPT_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `KPT_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_DONE, o_done && !busy)
    `KPT_ASSERT_IMP(a_done_count, i_clk, i_rst_n, o_done, o_result.entry_count == 8'(r_count))
endmodule
`default_nettype wire

### hdl/kpt_ram.sv
`default_nettype none
module kpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
